// File: rtl/core/wrmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wrmf_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_RADIUS_DEF = 3;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_RADIUS = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    localparam logic [1:0] MODE_MEDIAN = 2'd0;
    localparam logic [1:0] MODE_MEAN   = 2'd1;
    localparam logic [1:0] MODE_MIN    = 2'd2;
    localparam logic [1:0] MODE_MAX    = 2'd3;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pixel_t;

    typedef struct packed {
        logic [10:0] centre_column;
        logic [15:0] centre_row;
        logic [7:0]  out_blue;
        logic [7:0]  out_green;
        logic [7:0]  out_red;
        logic        frame_last;
    } result_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] radius;
    } filt_cfg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_STEP,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/wrmf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module wrmf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wrmf_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;

    assign full     = (count_reg == NW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wrmf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wrmf_front #(
    parameter int MAX_WIDTH  = wrmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = wrmf_pkg::MAX_RADIUS_DEF,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int RB    = $clog2(2 * MAX_RADIUS + 2),
    localparam int JOB_W = CW + RB + 16 + 11 + 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire wrmf_pkg::pixel_t    in_pix,
    output logic                     job_push,
    input  wire logic                job_full,
    output logic [JOB_W-1:0]         job_data,
    input  wire logic                pipe_empty,
    output logic                     mem_wr_en,
    output logic [RB+CW-1:0]         mem_wr_addr,
    output wrmf_pkg::pixel_t         mem_wr_data,
    output wrmf_pkg::filt_cfg_t      filt_cfg
);

    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (EW > 12) ? EW : 12;

    logic [1:0]    mode_reg;
    logic [1:0]    radius_reg;
    logic [11:0]   width_reg;
    logic [15:0]   height_reg;
    logic [CW-1:0] col_reg;
    logic [15:0]   row_reg;

    logic [EW-1:0] eff_w;
    logic [15:0]   eff_h;
    logic [1:0]    eff_r;
    logic [2:0]    two_r;
    logic          emit;
    logic          col_last;
    logic          row_last;
    logic          accept;

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = EW'(1);
        end
        else if (XW'(width_reg) > XW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW'(width_reg);
        end
        eff_h = (height_reg == '0) ? 16'd1 : height_reg;
        eff_r = ({1'b0, radius_reg} > 3'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : radius_reg;
    end

    assign two_r    = {eff_r, 1'b0};
    assign emit     = (row_reg >= 16'(two_r)) && (col_reg >= CW'(two_r));
    assign col_last = ((EW'(col_reg) + EW'(1)) == eff_w);
    assign row_last = (row_reg == eff_h - 16'd1);

    // Outside a run of emitting pixels in one row, the back end must be empty so
    // that no pending window read meets a line store write to the same entry.
    assign in_ready = !job_full && ((emit && (col_reg != '0)) || pipe_empty);
    assign accept   = in_valid && in_ready;

    assign job_push    = accept && emit;
    assign job_data    = {col_reg, row_reg[RB-1:0], row_reg - 16'(eff_r),
                          11'(col_reg - CW'(eff_r)), row_last && col_last};
    assign mem_wr_en   = accept;
    assign mem_wr_addr = {row_reg[RB-1:0], col_reg};
    assign mem_wr_data = in_pix;

    assign filt_cfg.mode   = mode_reg;
    assign filt_cfg.radius = eff_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= wrmf_pkg::MODE_MEDIAN;
            radius_reg <= 2'd1;
            width_reg  <= 12'd640;
            height_reg <= 16'd480;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                wrmf_pkg::CFG_MODE:
                begin
                    mode_reg <= cfg_wdata[1:0];
                end
                wrmf_pkg::CFG_RADIUS:
                begin
                    radius_reg <= cfg_wdata[1:0];
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                wrmf_pkg::CFG_WIDTH:
                begin
                    width_reg <= cfg_wdata[11:0];
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                wrmf_pkg::CFG_HEIGHT:
                begin
                    height_reg <= cfg_wdata;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_last ? 16'd0 : row_reg + 16'd1;
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wrmf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wrmf_back #(
    parameter int MAX_WIDTH  = wrmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = wrmf_pkg::MAX_RADIUS_DEF,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int RB    = $clog2(2 * MAX_RADIUS + 2),
    localparam int JOB_W = CW + RB + 16 + 11 + 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wrmf_pkg::filt_cfg_t filt_cfg,
    input  wire logic                job_avail,
    output logic                     job_pop,
    input  wire logic [JOB_W-1:0]    job_data,
    output logic                     idle,
    input  wire logic                mem_wr_en,
    input  wire logic [RB+CW-1:0]    mem_wr_addr,
    input  wire wrmf_pkg::pixel_t    mem_wr_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output wrmf_pkg::result_t        out_pix
);

    localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W   = $clog2(WIN_MAX + 1);
    localparam int SUM_W   = $clog2(255 * WIN_MAX + 1);

    wrmf_pkg::pixel_t line_mem [2 ** (RB + CW)];

    wrmf_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]    base_col_reg, base_col_next;
    logic [RB-1:0]    base_slot_reg, base_slot_next;
    logic [15:0]      c_row_reg, c_row_next;
    logic [10:0]      c_col_reg, c_col_next;
    logic             last_reg, last_next;
    logic [2:0]       d_reg, d_next;
    logic [2:0]       e_reg, e_next;
    logic [3:0]       pass_reg, pass_next;
    logic [2:0]       div_reg, div_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [23:0]      rd_data_reg;
    logic [SUM_W-1:0] sum_reg [3];
    logic [SUM_W-1:0] sum_next [3];
    logic [7:0]       mn_reg [3];
    logic [7:0]       mn_next [3];
    logic [7:0]       mx_reg [3];
    logic [7:0]       mx_next [3];
    logic [CNT_W-1:0] cnt_reg [3];
    logic [CNT_W-1:0] cnt_next [3];
    logic [CNT_W-1:0] tgt_reg [3];
    logic [CNT_W-1:0] tgt_next [3];
    logic [7:0]       med_reg [3];
    logic [7:0]       med_next [3];
    logic [7:0]       quot_reg [3];
    logic [7:0]       quot_next [3];
    logic             out_valid_reg, out_valid_next;
    wrmf_pkg::result_t out_data_reg, out_data_next;

    logic [2:0]       span_m1;
    logic [CNT_W-1:0] k_cnt;
    logic [2:0]       two_r;
    logic [2:0]       bit_idx;
    logic             rd_en;
    logic [RB+CW-1:0] rd_addr;
    logic [SUM_W-1:0] div_sub;
    logic [7:0]       res_val [3];
    logic [7:0]       pix_val;

    assign two_r   = {filt_cfg.radius, 1'b0};
    assign span_m1 = two_r;
    assign bit_idx = 3'(4'd8 - pass_reg);
    assign rd_addr = {base_slot_reg + RB'(d_reg), base_col_reg + CW'(e_reg)};
    assign idle    = (state_reg == wrmf_pkg::BK_IDLE);
    assign out_valid = out_valid_reg;
    assign out_pix   = out_data_reg;
    assign div_sub = SUM_W'(k_cnt) << div_reg;

    always_comb
    begin
        case (filt_cfg.radius)
            2'd0:    k_cnt = CNT_W'(1);
            2'd1:    k_cnt = CNT_W'(9);
            2'd2:    k_cnt = CNT_W'(25);
            default: k_cnt = CNT_W'(49);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            line_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        base_col_next  = base_col_reg;
        base_slot_next = base_slot_reg;
        c_row_next     = c_row_reg;
        c_col_next     = c_col_reg;
        last_next      = last_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        pass_next      = pass_reg;
        div_next       = div_reg;
        rd_vld_next    = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        job_pop        = 1'b0;
        rd_en          = 1'b0;
        pix_val        = '0;
        for (int c = 0; c < 3; c++)
        begin
            sum_next[c]  = sum_reg[c];
            mn_next[c]   = mn_reg[c];
            mx_next[c]   = mx_reg[c];
            cnt_next[c]  = cnt_reg[c];
            tgt_next[c]  = tgt_reg[c];
            med_next[c]  = med_reg[c];
            quot_next[c] = quot_reg[c];
            case (filt_cfg.mode)
                wrmf_pkg::MODE_MEDIAN: res_val[c] = med_reg[c];
                wrmf_pkg::MODE_MEAN:   res_val[c] = quot_reg[c];
                wrmf_pkg::MODE_MIN:    res_val[c] = mn_reg[c];
                default:               res_val[c] = mx_reg[c];
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (rd_vld_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pix_val = rd_data_reg[8*c +: 8];
                if (pass_reg == '0)
                begin
                    sum_next[c] = sum_reg[c] + SUM_W'(pix_val);
                    if (pix_val < mn_reg[c])
                    begin
                        mn_next[c] = pix_val;
                    end
                    if (pix_val > mx_reg[c])
                    begin
                        mx_next[c] = pix_val;
                    end
                end
                else if ((pix_val >> bit_idx) == (med_reg[c] >> bit_idx))
                begin
                    cnt_next[c] = cnt_reg[c] + CNT_W'(1);
                end
            end
        end

        case (state_reg)
            wrmf_pkg::BK_IDLE:
            begin
                if (job_avail)
                begin
                    job_pop        = 1'b1;
                    base_col_next  = job_data[JOB_W-1 -: CW] - CW'(two_r);
                    base_slot_next = job_data[JOB_W-CW-1 -: RB] - RB'(two_r);
                    c_row_next     = job_data[27:12];
                    c_col_next     = job_data[11:1];
                    last_next      = job_data[0];
                    d_next         = '0;
                    e_next         = '0;
                    pass_next      = (filt_cfg.mode == wrmf_pkg::MODE_MEDIAN) ? 4'd1 : 4'd0;
                    for (int c = 0; c < 3; c++)
                    begin
                        sum_next[c]  = '0;
                        mn_next[c]   = 8'hFF;
                        mx_next[c]   = 8'h00;
                        cnt_next[c]  = '0;
                        tgt_next[c]  = (k_cnt - CNT_W'(1)) >> 1;
                        med_next[c]  = '0;
                        quot_next[c] = '0;
                    end
                    state_next = wrmf_pkg::BK_SCAN;
                end
            end
            wrmf_pkg::BK_SCAN:
            begin
                rd_en       = 1'b1;
                rd_vld_next = 1'b1;
                if (e_reg == span_m1)
                begin
                    e_next = '0;
                    if (d_reg == span_m1)
                    begin
                        state_next = wrmf_pkg::BK_DRAIN;
                    end
                    else
                    begin
                        d_next = d_reg + 3'd1;
                    end
                end
                else
                begin
                    e_next = e_reg + 3'd1;
                end
            end
            wrmf_pkg::BK_DRAIN:
            begin
                state_next = wrmf_pkg::BK_STEP;
            end
            wrmf_pkg::BK_STEP:
            begin
                if (filt_cfg.mode == wrmf_pkg::MODE_MEDIAN)
                begin
                    // Walk down one rank bit: keep a zero if the target rank falls
                    // among the values whose current prefix ends in zero.
                    for (int c = 0; c < 3; c++)
                    begin
                        cnt_next[c] = '0;
                        if (tgt_reg[c] >= cnt_reg[c])
                        begin
                            med_next[c] = med_reg[c] | (8'd1 << bit_idx);
                            tgt_next[c] = tgt_reg[c] - cnt_reg[c];
                        end
                    end
                    if (pass_reg == 4'd8)
                    begin
                        state_next = wrmf_pkg::BK_OUT;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 4'd1;
                        d_next     = '0;
                        e_next     = '0;
                        state_next = wrmf_pkg::BK_SCAN;
                    end
                end
                else if (filt_cfg.mode == wrmf_pkg::MODE_MEAN)
                begin
                    div_next   = 3'd7;
                    state_next = wrmf_pkg::BK_DIV;
                end
                else
                begin
                    state_next = wrmf_pkg::BK_OUT;
                end
            end
            wrmf_pkg::BK_DIV:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (sum_reg[c] >= div_sub)
                    begin
                        sum_next[c]  = sum_reg[c] - div_sub;
                        quot_next[c] = quot_reg[c] | (8'd1 << div_reg);
                    end
                end
                div_next = div_reg - 3'd1;
                if (div_reg == '0)
                begin
                    state_next = wrmf_pkg::BK_OUT;
                end
            end
            wrmf_pkg::BK_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.centre_column = c_col_reg;
                    out_data_next.centre_row    = c_row_reg;
                    out_data_next.out_blue      = res_val[0];
                    out_data_next.out_green     = res_val[1];
                    out_data_next.out_red       = res_val[2];
                    out_data_next.frame_last    = last_reg;
                    state_next                  = wrmf_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = wrmf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrmf_pkg::BK_IDLE;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_col_reg  <= base_col_next;
        base_slot_reg <= base_slot_next;
        c_row_reg     <= c_row_next;
        c_col_reg     <= c_col_next;
        last_reg      <= last_next;
        d_reg         <= d_next;
        e_reg         <= e_next;
        pass_reg      <= pass_next;
        div_reg       <= div_next;
        out_data_reg  <= out_data_next;
        for (int c = 0; c < 3; c++)
        begin
            sum_reg[c]  <= sum_next[c];
            mn_reg[c]   <= mn_next[c];
            mx_reg[c]   <= mx_next[c];
            cnt_reg[c]  <= cnt_next[c];
            tgt_reg[c]  <= tgt_next[c];
            med_reg[c]  <= med_next[c];
            quot_reg[c] <= quot_next[c];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/window_rank_mean_filter.sv
// Operation: for a pixel that completes a window, the back end reads its N = (2r+1)^2
// entries from the line store, one read per cycle: once for minimum and maximum, once
// plus eight division steps for the mean, and once per result bit for the median.
// Window pixels queue while it works; border pixels, one a cycle once it has drained.
// Reset: counters, queue and handshake state clear; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module window_rank_mean_filter #(
    parameter int MAX_WIDTH  = wrmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = wrmf_pkg::MAX_RADIUS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire wrmf_pkg::pixel_t  in_pix,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wrmf_pkg::result_t      out_pix
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RB    = $clog2(2 * MAX_RADIUS + 2);
    localparam int JOB_W = CW + RB + 16 + 11 + 1;

    logic                job_push;
    logic                job_full;
    logic                job_empty;
    logic                job_pop;
    logic [JOB_W-1:0]    job_in;
    logic [JOB_W-1:0]    job_out;
    logic                back_idle;
    logic                mem_wr_en;
    logic [RB+CW-1:0]    mem_wr_addr;
    wrmf_pkg::pixel_t    mem_wr_data;
    wrmf_pkg::filt_cfg_t filt_cfg;

    wrmf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_pix      (in_pix),
        .job_push    (job_push),
        .job_full    (job_full),
        .job_data    (job_in),
        .pipe_empty  (job_empty && back_idle),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .filt_cfg    (filt_cfg)
    );

    wrmf_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (wrmf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty)
    );

    wrmf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .filt_cfg    (filt_cfg),
        .job_avail   (!job_empty),
        .job_pop     (job_pop),
        .job_data    (job_out),
        .idle        (back_idle),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_pix     (out_pix)
    );

endmodule

`default_nettype wire

// File: tb/window_rank_mean_filter_test.sv
`timescale 1ns / 1ps

module window_rank_mean_filter_test;
    import wrmf_pkg::*;

    localparam int KEPT_ROWS = 2 * MAX_RADIUS_DEF + 1;
    localparam int SETTLE_CYCLES = 500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_MODE;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    pixel_t      in_pix = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    result_t     out_pix;

    window_rank_mean_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_pix    (in_pix),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pix   (out_pix)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pixel_t      row_mem [KEPT_ROWS][MAX_WIDTH_DEF];
    logic [1:0]  mode_reg = MODE_MEDIAN;
    logic [1:0]  radius_reg = 2'd1;
    logic [11:0] width_reg = 12'd640;
    logic [15:0] height_reg = 16'd480;
    int          col_pos = 0;
    int          row_pos = 0;
    result_t     expected_pixels[$];
    int          error_count = 0;
    int          pixels_sent = 0;
    int          burst_left = 0;

    function automatic logic [7:0] reduce_channel(input logic [7:0] v[49], input int count);
        logic [7:0] s[49];
        logic [7:0] key;
        logic [7:0] lo;
        logic [7:0] hi;
        int sum;
        int j;
        s = v;
        sum = 0;
        lo = s[0];
        hi = s[0];
        for (int i = 0; i < count; i++)
        begin
            sum += s[i];
            if (s[i] < lo) lo = s[i];
            if (s[i] > hi) hi = s[i];
        end
        case (mode_reg)
            MODE_MEAN: return 8'(sum / count);
            MODE_MIN:  return lo;
            MODE_MAX:  return hi;
            default:
            begin
                for (int i = 1; i < count; i++)
                begin
                    key = s[i];
                    j = i;
                    while (j > 0 && s[j - 1] > key)
                    begin
                        s[j] = s[j - 1];
                        j--;
                    end
                    s[j] = key;
                end
                return s[(count - 1) / 2];
            end
        endcase
    endfunction

    task automatic predict_pixel(input pixel_t p);
        int w;
        int h;
        int r;
        int span;
        int k;
        int rr;
        logic [7:0] blues[49];
        logic [7:0] greens[49];
        logic [7:0] reds[49];
        result_t res;
        pixel_t q;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        r = radius_reg;
        span = 2 * r + 1;
        if (col_pos >= w) col_pos = w - 1;
        if (row_pos >= h) row_pos = h - 1;
        row_mem[row_pos % KEPT_ROWS][col_pos] = p;
        if (row_pos >= 2 * r && col_pos >= 2 * r)
        begin
            k = 0;
            blues = '{default: '0};
            greens = '{default: '0};
            reds = '{default: '0};
            for (int d = 0; d < span; d++)
            begin
                rr = (row_pos - 2 * r + d) % KEPT_ROWS;
                for (int e = 0; e < span; e++)
                begin
                    q = row_mem[rr][col_pos - 2 * r + e];
                    blues[k] = q.in_blue;
                    greens[k] = q.in_green;
                    reds[k] = q.in_red;
                    k++;
                end
            end
            res.centre_column = 11'(col_pos - r);
            res.centre_row = 16'(row_pos - r);
            res.out_blue = reduce_channel(blues, k);
            res.out_green = reduce_channel(greens, k);
            res.out_red = reduce_channel(reds, k);
            res.frame_last = (row_pos == h - 1) && (col_pos == w - 1);
            expected_pixels.push_back(res);
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // Called at a falling edge; returns at a falling edge.
    task automatic send_pixel(input pixel_t p);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_pix <= p;
        do @(posedge clk); while (!in_ready);
        predict_pixel(p);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(pixel_t'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (expected_pixels.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MODE:   mode_reg = data[1:0];
            CFG_RADIUS: radius_reg = data[1:0];
            CFG_WIDTH:  width_reg = data[11:0];
            default:    height_reg = data;
        endcase
        if (idx != CFG_MODE)
        begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    task automatic set_geometry(input logic [1:0] mode, input logic [1:0] r,
                                input logic [15:0] w, input logic [15:0] h);
        wait_idle();
        write_reg(CFG_MODE, 16'(mode));
        write_reg(CFG_RADIUS, 16'(r));
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    task automatic test_reset_defaults();
        send_pixel(pixel_t'(24'h000000));
        send_pixel(pixel_t'(24'hFFFFFF));
        send_random(4);
    endtask

    task automatic test_small_frame();
        pixel_t pattern[16];
        for (int i = 0; i < 16; i++)
            pattern[i] = (i % 3 == 0) ? 24'hFFFFFF : ((i % 3 == 1) ? 24'h000000 : 24'h55AA01);
        set_geometry(MODE_MEDIAN, 2'd1, 16'd4, 16'd4);
        foreach (pattern[i]) send_pixel(pattern[i]);
    endtask

    task automatic test_degenerate_sizes();
        set_geometry(MODE_MAX, 2'd0, 16'd0, 16'd0);
        send_random(3);
        set_geometry(MODE_MIN, 2'd3, 16'd5, 16'd5);
        send_random(6);
        set_geometry(MODE_MEAN, 2'd0, 16'hFFFF, 16'hFFFF);
        send_random(5);
    endtask

    task automatic test_random_frames();
        int r;
        int w;
        int h;
        int n;
        while (pixels_sent < 1950)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                r = $urandom_range(0, 1);
                set_geometry(2'($urandom), 2'(r), 16'($urandom_range(2040, 4095)),
                             16'($urandom_range(2, 65535)));
                send_random($urandom_range(10, 40));
                continue;
            end
            r = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1) : $urandom_range(2, 3);
            w = $urandom_range(0, 2 * r + 6);
            h = $urandom_range(0, 2 * r + 5);
            set_geometry(2'($urandom), 2'(r), 16'(w), 16'(h));
            if (w == 0) w = 1;
            if (h == 0) h = 1;
            n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
            send_random(n);
        end
    endtask

    always @(negedge clk)
    begin
        case (($time / 512) % 3)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, actual %p", $time, out_pix);
                error_count++;
            end
            else
            begin
                if (out_pix.centre_column !== expected_pixels[0].centre_column ||
                    out_pix.centre_row !== expected_pixels[0].centre_row ||
                    out_pix.out_blue !== expected_pixels[0].out_blue ||
                    out_pix.out_green !== expected_pixels[0].out_green ||
                    out_pix.out_red !== expected_pixels[0].out_red ||
                    out_pix.frame_last !== expected_pixels[0].frame_last)
                begin
                    $display("%0t: mismatch, expected %p, actual %p",
                             $time, expected_pixels[0], out_pix);
                    error_count++;
                end
                void'(expected_pixels.pop_front());
            end
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_small_frame();
        test_degenerate_sizes();
        test_random_frames();
        wait_idle();
        if (expected_pixels.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
